/* src/lphi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lphi_pkg;

    // Table geometry: slot count must be a power of two (home slot is a mask)
    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int STEP_W      = $clog2(TABLE_SLOTS + 1);
    localparam int MAX_RESULTS = 64;
    localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int KEY_W   = 32;
    localparam int ROW_W   = 16;
    localparam int CNT_W   = 7;
    localparam int ENTRY_W = KEY_W + ROW_W;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_COUNT  = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic [ROW_W-1:0] found_row;
        logic             found;
        logic             last;
        logic             full_res;
    } res_t;

    // Write and read requests to the slot store
    typedef struct packed {
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

/* src/lphi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lphi_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/lphi_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lphi_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // command beat
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire logic [1:0]                in_cmd,
    input  wire logic [lphi_pkg::KEY_W-1:0] in_key,
    input  wire logic [lphi_pkg::ROW_W-1:0] in_row,
    // result beat
    output      logic                      res_valid,
    input  wire logic                      res_ready,
    output      lphi_pkg::res_t            res,
    // slot store
    output      lphi_pkg::mem_req_t        mem_req,
    input  wire logic [lphi_pkg::ENTRY_W-1:0] mem_rd_data
);

    import lphi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_EMIT
    } state_t;

    state_t            state_reg,    state_next;
    cmd_t              cmd_reg,      cmd_next;
    logic [KEY_W-1:0]  key_reg,      key_next;
    logic [ROW_W-1:0]  row_reg,      row_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [STEP_W-1:0] step_reg,     step_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [HIT_W-1:0]  hits_reg,     hits_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [ROW_W-1:0]  pend_row_reg, pend_row_next;
    logic              done_reg,     done_next;
    res_t              res_reg,      res_next;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;

    logic              probe_end;
    logic              key_hit;
    logic [SLOT_W-1:0] slot_inc;
    logic [KEY_W-1:0]  rd_key;
    logic [ROW_W-1:0]  rd_row;

    assign rd_key = mem_rd_data[KEY_W-1:0];
    assign rd_row = mem_rd_data[ENTRY_W-1:KEY_W];

    // next slot with wrap at the end of the table
    assign slot_inc = (slot_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;

    // a probe stops at an empty slot, after one full pass, or at the match limit
    assign probe_end = (step_reg == STEP_W'(TABLE_SLOTS)) || !used_reg[slot_reg]
                       || (hits_reg == HIT_W'(MAX_RESULTS));
    assign key_hit   = (rd_key == key_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        row_next      = row_reg;
        slot_next     = slot_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        hits_next     = hits_reg;
        pend_vld_next = pend_vld_reg;
        pend_row_next = pend_row_reg;
        done_next     = done_reg;
        res_next      = res_reg;
        used_next     = used_reg;
        mem_req       = '0;
        mem_req.wr_addr = slot_reg;
        mem_req.wr_data = {row_reg, key_reg};
        mem_req.rd_addr = slot_reg;

        unique case (state_reg)
            // take a command beat and start at the home slot
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next      = cmd_t'(in_cmd);
                    key_next      = in_key;
                    row_next      = in_row;
                    slot_next     = in_key[SLOT_W-1:0];
                    step_next     = '0;
                    cnt_next      = '0;
                    hits_next     = '0;
                    pend_vld_next = 1'b0;
                    state_next    = ST_PROBE;
                end
            end

            // look at the current slot
            ST_PROBE: begin
                res_next      = '0;
                res_next.last = 1'b1;
                done_next     = 1'b1;
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        if (step_reg == STEP_W'(TABLE_SLOTS)) begin
                            res_next.full_res = 1'b1;
                            state_next        = ST_EMIT;
                        end else if (!used_reg[slot_reg]) begin
                            mem_req.wr_en       = 1'b1;
                            used_next[slot_reg] = 1'b1;
                            state_next          = ST_EMIT;
                        end else begin
                            slot_next = slot_inc;
                            step_next = step_reg + 1'b1;
                        end
                    end
                    CMD_COUNT: begin
                        if (probe_end) begin
                            res_next.match_count = cnt_reg;
                            state_next           = ST_EMIT;
                        end else begin
                            mem_req.rd_en = 1'b1;
                            state_next    = ST_CMP;
                        end
                    end
                    CMD_LIST: begin
                        if (probe_end) begin
                            // held match is the final one
                            res_next.found     = pend_vld_reg;
                            res_next.found_row = pend_vld_reg ? pend_row_reg : '0;
                            state_next         = ST_EMIT;
                        end else begin
                            mem_req.rd_en = 1'b1;
                            state_next    = ST_CMP;
                        end
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end

            // stored entry is back: compare and step on
            ST_CMP: begin
                slot_next  = slot_inc;
                step_next  = step_reg + 1'b1;
                state_next = ST_PROBE;
                if (key_hit) begin
                    if (cmd_reg == CMD_COUNT) begin
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else begin
                        // hold the new match; send the older one, which is not last
                        hits_next     = hits_reg + 1'b1;
                        pend_vld_next = 1'b1;
                        pend_row_next = rd_row;
                        if (pend_vld_reg) begin
                            res_next           = '0;
                            res_next.found     = 1'b1;
                            res_next.found_row = pend_row_reg;
                            done_next          = 1'b0;
                            state_next         = ST_EMIT;
                        end
                    end
                end
            end

            // hand the result beat over
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = done_reg ? ST_IDLE : ST_PROBE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            pend_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            pend_vld_reg <= pend_vld_next;
            done_reg     <= done_next;
        end
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        row_reg      <= row_next;
        slot_reg     <= slot_next;
        step_reg     <= step_next;
        cnt_reg      <= cnt_next;
        hits_reg     <= hits_next;
        pend_row_reg <= pend_row_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

/* src/linear_probe_hash_index_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Linear-probing hash index over 32-bit keys, 64 slots, duplicates allowed.
// Input stream: s_tuser carries the command (insert, count, list), s_tdata
// the key and the row reference. One command is taken at a time.
// Output stream: insert and count give one beat with m_tlast set; list gives
// one beat per matching row in probe order (at most 64), the final one with
// m_tlast, or a single not-found beat.
// Timing: the home slot is the low key bits. Insert steps past each occupied
// slot in turn and writes the first free one. Count and list read the store
// and then compare for each occupied slot, and each extra list beat goes out
// through the emit state before the probe resumes. The registered read port
// of the slot store sets the read-then-compare step.
// Reset: occupancy flags clear in the reset cycle, so the table is empty at
// once, with no clearing pass. Stored keys and rows are not reset.
// Stall: a result waits in the output register while m_tready is low; the
// probe holds until it is taken, and the next command is taken meanwhile
// once the previous command has produced all of its beats.

module linear_probe_hash_index_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [47:0] s_tdata,   // key [31:0], row_ref [47:32]
    input  wire logic [1:0]  s_tuser,   // command [1:0]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [31:0] m_tdata,   // match_count [6:0], found_row [22:7],
                                        // found [23], full_res [24], zero [31:25]
    output      logic        m_tlast
);

    import lphi_pkg::*;

    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               m_tvalid_reg;
    res_t               m_res_reg;

    lphi_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    lphi_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_row      (s_tdata[ENTRY_W-1:KEY_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // output register: refills whenever empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {7'd0, m_res_reg.full_res, m_res_reg.found,
                       m_res_reg.found_row, m_res_reg.match_count};

endmodule

`default_nettype wire

/* src/lphi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lphi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // one command at a time: no second accept right after one
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while one is in progress");

    // only list matches come as beats that are not last
    a_mid_is_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[23] && (m_tdata[6:0] == 7'd0))
        else $error("non-final beat is not a list match");

    // a refused insert never reports a match
    a_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> !m_tdata[23] && m_tlast)
        else $error("full flag with match or without last");

endmodule

bind linear_probe_hash_index_unit lphi_checker u_lphi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/linear_probe_hash_index_checker.sv */
`timescale 1ns / 1ps

module linear_probe_hash_index_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // key [31:0], row_ref [47:32]
    input  logic [1:0]  s_tuser,    // command [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // match_count [6:0], found_row [22:7],
                                    // found [23], full_res [24], zero [31:25]
    input  logic        m_tlast,
    output int          fail_count,
    output int          beats_due
);
    import lphi_pkg::*;

    // Shadow copy of the slot store
    logic             used_q [TABLE_SLOTS];
    logic [KEY_W-1:0] key_q  [TABLE_SLOTS];
    logic [ROW_W-1:0] row_q  [TABLE_SLOTS];

    // Result beats the block still owes, oldest first
    res_t owed_beats [$];
    res_t oldest;
    int   n_fail = 0;
    int   n_owed = 0;

    assign fail_count = n_fail;
    assign beats_due  = n_owed;

    // Apply one command to the shadow table and queue the beats it yields
    task automatic run_command(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [ROW_W-1:0] row);
        logic [SLOT_W-1:0] s;
        int                n;
        int                hits;
        logic              stop;
        logic [CNT_W-1:0]  cnt;
        res_t              beat;
        res_t              held;
        s         = key[SLOT_W-1:0];
        n         = 0;
        hits      = 0;
        stop      = 1'b0;
        cnt       = '0;
        beat      = '0;
        held      = '0;
        beat.last = 1'b1;
        case (cmd)
            CMD_INSERT: begin
                // first free slot from home; a full table refuses
                beat.full_res = 1'b1;
                while (n < TABLE_SLOTS && !stop) begin
                    if (!used_q[s]) begin
                        used_q[s]     = 1'b1;
                        key_q[s]      = key;
                        row_q[s]      = row;
                        beat.full_res = 1'b0;
                        stop          = 1'b1;
                    end
                    s = s + 1'b1;
                    n++;
                end
                owed_beats.push_back(beat);
            end
            CMD_COUNT: begin
                // walk the cluster, at most one full pass
                while (n < TABLE_SLOTS && used_q[s]) begin
                    if (key_q[s] == key && cnt != COUNT_MAX)
                        cnt++;
                    s = s + 1'b1;
                    n++;
                end
                beat.match_count = cnt;
                owed_beats.push_back(beat);
            end
            CMD_LIST: begin
                // a match is queued once the next one shows; the final one carries last
                while (n < TABLE_SLOTS && used_q[s] && hits < MAX_RESULTS) begin
                    if (key_q[s] == key) begin
                        if (hits != 0)
                            owed_beats.push_back(held);
                        held           = '0;
                        held.found     = 1'b1;
                        held.found_row = row_q[s];
                        hits++;
                    end
                    s = s + 1'b1;
                    n++;
                end
                if (hits != 0) begin
                    beat      = held;
                    beat.last = 1'b1;
                end
                owed_beats.push_back(beat);
            end
            default: begin
                // unknown command: bare last beat
                owed_beats.push_back(beat);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    // Commands first, so a beat is always matched against a complete queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                used_q[i] = 1'b0;
            owed_beats.delete();
        end else begin
            if (s_tvalid && s_tready)
                run_command(s_tuser, s_tdata[KEY_W-1:0], s_tdata[ENTRY_W-1:KEY_W]);
            if (m_tvalid && m_tready) begin
                if (owed_beats.size() == 0) begin
                    $error("result beat with none expected: m_tdata %0h, m_tlast %0b",
                           m_tdata, m_tlast);
                    n_fail++;
                end else begin
                    oldest = owed_beats.pop_front();
                    check_field("match_count", oldest.match_count, m_tdata[6:0]);
                    check_field("found_row", oldest.found_row, m_tdata[22:7]);
                    check_field("found", oldest.found, m_tdata[23]);
                    check_field("full_res", oldest.full_res, m_tdata[24]);
                    check_field("zero_pad", '0, m_tdata[31:25]);
                    check_field("last", oldest.last, m_tlast);
                end
            end
        end
        n_owed = owed_beats.size();
    end

endmodule

/* tb/linear_probe_hash_index_unit_tb.sv */
`timescale 1ns / 1ps

module linear_probe_hash_index_unit_tb;
    import lphi_pkg::*;

    // Command code outside the enum; the block answers with a bare last beat
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int POOL_N      = 8;
    localparam int HOLD_AT     = 30;     // beat count at which the sink backs off
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 150;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int fail_count;
    int beats_due;
    int n_stored    = 0;
    int n_sent      = 0;
    int n_taken     = 0;
    int idle_cycles = 0;

    // Keys reused often, so duplicates and long clusters build up
    logic [31:0] key_pool [POOL_N];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    linear_probe_hash_index_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    linear_probe_hash_index_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .beats_due  (beats_due)
    );

    // Mostly pooled keys; the rest land near the wrap point or anywhere
    function automatic logic [31:0] draw_key();
        int          roll;
        logic [31:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return key_pool[0];
        if (roll < 55)
            return key_pool[$urandom_range(1, POOL_N - 1)];
        k = $urandom();
        if (roll < 80)
            k[5:0] = 6'd62 + 6'($urandom_range(0, 4));
        return k;
    endfunction

    function automatic logic [1:0] draw_cmd(input int insert_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct)
            return CMD_INSERT;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return CMD_UNUSED;
        if (roll < 50)
            return CMD_COUNT;
        return CMD_LIST;
    endfunction

    // One input beat: optional gap, then hold until taken
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [15:0] row);
        int gap;
        if ((n_sent / 40) % 3 == 1)
            gap = 0;
        else
            gap = $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {row, key};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (cmd == CMD_INSERT && n_stored < TABLE_SLOTS)
            n_stored++;
    endtask

    // Stop offering until every owed beat has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (beats_due != 0)
            @(negedge aclk);
    endtask

    // Sink: random back-off per beat, calm stretches, one long hold
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (n_taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else if ((n_taken / 50) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 17);
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            n_taken++;
        end
    end

    // Watchdog on cycles without any beat moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [31:0] k;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        // pool: four homes around the wrap point, four spread out
        for (int i = 0; i < POOL_N; i++) begin
            k = $urandom();
            if (i < 4)
                k[5:0] = 6'd62 + 6'(i);
            else
                k[5:0] = 6'(i * 10);
            key_pool[i] = k;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, wrap-around, duplicates, misses
        send_cmd(CMD_LIST,   32'h0000_0000, 16'h0000);
        send_cmd(CMD_COUNT,  32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_INSERT, 32'h0000_0000, 16'h0000);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_INSERT, 32'h0000_003F, 16'h1234);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hAAAA);
        send_cmd(CMD_INSERT, 32'h0000_0040, 16'h5555);
        send_cmd(CMD_INSERT, 32'h5555_5555, 16'h5A5A);
        send_cmd(CMD_COUNT,  32'hFFFF_FFFF, 16'h0000);
        send_cmd(CMD_LIST,   32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_LIST,   32'h0000_003F, 16'h0000);
        send_cmd(CMD_LIST,   32'h0000_007F, 16'h0000);
        send_cmd(CMD_COUNT,  32'h0000_0000, 16'hFFFF);
        send_cmd(CMD_COUNT,  32'h8000_0000, 16'h0000);
        send_cmd(CMD_LIST,   32'h0000_0040, 16'h0000);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_UNUSED, 32'h0000_0000, 16'h0000);
        wait_drained();

        // random load-up of the table
        for (int i = 0; i < 180; i++)
            send_cmd(draw_cmd(30), draw_key(), $urandom());
        wait_drained();

        // top up to a full table, then refusals and full-pass probes
        while (n_stored < TABLE_SLOTS)
            send_cmd(CMD_INSERT, ($urandom_range(0, 1) != 0) ? key_pool[0] : draw_key(),
                     $urandom());
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_INSERT, 32'h0000_0000, 16'h0000);
        send_cmd(CMD_COUNT,  key_pool[0], 16'h0000);
        send_cmd(CMD_LIST,   key_pool[0], 16'h0000);
        send_cmd(CMD_COUNT,  32'hA5A5_A5A5, 16'h0000);
        send_cmd(CMD_LIST,   32'hA5A5_A5A5, 16'h0000);

        // random traffic on the full table
        for (int i = 0; i < 110; i++)
            send_cmd(draw_cmd(15), draw_key(), $urandom());

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && beats_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/lphi_pkg.sv
src/lphi_ram.sv
src/lphi_ctrl.sv
src/linear_probe_hash_index_unit.sv
src/lphi_checker.sv
tb/linear_probe_hash_index_checker.sv
tb/linear_probe_hash_index_unit_tb.sv
